>>> src/iap_command_framer_core_macros.svh
// Assertion helpers shared by the framer RTL.
// Each macro expands to one labeled concurrent assertion, sampled on the
// rising edge of the given clock and disabled while reset is high.
`ifndef IAP_COMMAND_FRAMER_CORE_MACROS_SVH
`define IAP_COMMAND_FRAMER_CORE_MACROS_SVH

// Same-cycle implication.
`define IAPCF_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("iapcf assertion failed");

// Next-cycle implication.
`define IAPCF_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("iapcf assertion failed");

`endif

>>> src/iapcf_pkg.sv
// ----------------------------------------------------------------------------
// iapcf_pkg
// Types and constants of the command framer: beat structs, frame marker
// bytes and the per-item burst of frame bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package iapcf_pkg;

  localparam logic [7:0] HdrA     = 8'hAA;
  localparam logic [7:0] HdrB     = 8'h55;
  localparam int         MaxBeats = 9;
  localparam int         CntW     = $clog2(MaxBeats + 1);

  typedef struct packed {
    logic       first;
    logic [7:0] cmd;
    logic [7:0] frame_len;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } out_item_t;

  // Bytes one item produces, entry 0 goes out first.
  typedef struct packed {
    logic [MaxBeats-1:0][7:0] bytes;
    logic [CntW-1:0]          count;
    logic                     has_end;
  } burst_t;

endpackage

`default_nettype wire

>>> src/iapcf_in_buf.sv
// ----------------------------------------------------------------------------
// iapcf_in_buf
// Two-entry input skid buffer; stall comes straight from a register so the
// input side never waits on the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

`include "iap_command_framer_core_macros.svh"

module iapcf_in_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire iapcf_pkg::in_item_t item,
  output logic                   head_valid,
  output iapcf_pkg::in_item_t    head,
  input  wire logic              pop
);

  iapcf_pkg::in_item_t e0;
  iapcf_pkg::in_item_t e1;
  logic [1:0]          cnt;
  logic                push;

  assign item_stall = (cnt == 2'd2);
  assign push       = item_valid && !item_stall;
  assign head_valid = (cnt != 2'd0);
  assign head       = e0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10: begin
          if (cnt == 2'd0) begin
            e0 <= item;
          end else begin
            e1 <= item;
          end
          cnt <= cnt + 2'd1;
        end
        2'b01: begin
          e0  <= e1;
          cnt <= cnt - 2'd1;
        end
        2'b11: begin
          if (cnt == 2'd1) begin
            e0 <= item;
          end else begin
            e0 <= e1;
            e1 <= item;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `IAPCF_ASSERT_NOW(a_pop_nonempty, clk, rst, pop, cnt != 2'd0)
  `IAPCF_ASSERT_NOW(a_cnt_range, clk, rst, 1'b1, cnt != 2'd3)

endmodule

`default_nettype wire

>>> src/iapcf_frame_calc.sv
// ----------------------------------------------------------------------------
// iapcf_frame_calc
// Frame state (running sum, bytes left, open flag) and the logic that turns
// one item into its burst of frame bytes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "iap_command_framer_core_macros.svh"

module iapcf_frame_calc (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire iapcf_pkg::in_item_t item,
  output iapcf_pkg::burst_t        burst
);

  logic [15:0] running_sum;
  logic [7:0]  bytes_left;
  logic        frame_open;
  logic [15:0] running_sum_next;
  logic [7:0]  bytes_left_next;
  logic        frame_open_next;

  logic [15:0] sum_first;
  logic [15:0] sum_pay;

  always_comb begin
    sum_first = {8'h00, item.cmd} + {8'h00, item.frame_len};
    sum_pay   = (item.first ? sum_first : running_sum) + {8'h00, item.data_byte};
  end

  always_comb begin
    burst            = '0;
    running_sum_next = running_sum;
    bytes_left_next  = bytes_left;
    frame_open_next  = frame_open;
    priority if (item.first) begin
      burst.bytes[0] = iapcf_pkg::HdrA;
      burst.bytes[1] = iapcf_pkg::HdrB;
      burst.bytes[2] = item.cmd;
      burst.bytes[3] = item.frame_len;
      if (item.frame_len == 8'd0) begin
        // empty payload: trailer right after the length
        burst.bytes[4]   = sum_first[7:0];
        burst.bytes[5]   = sum_first[15:8];
        burst.bytes[6]   = iapcf_pkg::HdrB;
        burst.bytes[7]   = iapcf_pkg::HdrA;
        burst.count      = iapcf_pkg::CntW'(8);
        burst.has_end    = 1'b1;
        running_sum_next = sum_first;
        bytes_left_next  = 8'd0;
        frame_open_next  = 1'b0;
      end else begin
        burst.bytes[4]   = item.data_byte;
        running_sum_next = sum_pay;
        if (item.frame_len == 8'd1) begin
          burst.bytes[5]  = sum_pay[7:0];
          burst.bytes[6]  = sum_pay[15:8];
          burst.bytes[7]  = iapcf_pkg::HdrB;
          burst.bytes[8]  = iapcf_pkg::HdrA;
          burst.count     = iapcf_pkg::CntW'(9);
          burst.has_end   = 1'b1;
          bytes_left_next = 8'd0;
          frame_open_next = 1'b0;
        end else begin
          burst.count     = iapcf_pkg::CntW'(5);
          bytes_left_next = item.frame_len - 8'd1;
          frame_open_next = 1'b1;
        end
      end
    end else if (frame_open && bytes_left != 8'd0) begin
      burst.bytes[0]   = item.data_byte;
      running_sum_next = sum_pay;
      if (bytes_left == 8'd1) begin
        burst.bytes[1]  = sum_pay[7:0];
        burst.bytes[2]  = sum_pay[15:8];
        burst.bytes[3]  = iapcf_pkg::HdrB;
        burst.bytes[4]  = iapcf_pkg::HdrA;
        burst.count     = iapcf_pkg::CntW'(5);
        burst.has_end   = 1'b1;
        bytes_left_next = 8'd0;
        frame_open_next = 1'b0;
      end else begin
        burst.count     = iapcf_pkg::CntW'(1);
        bytes_left_next = bytes_left - 8'd1;
      end
    end else begin
      // stray payload byte: drop it, no beats
      burst.count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= 16'd0;
      bytes_left  <= 8'd0;
      frame_open  <= 1'b0;
    end else if (load) begin
      running_sum <= running_sum_next;
      bytes_left  <= bytes_left_next;
      frame_open  <= frame_open_next;
    end
  end

  `IAPCF_ASSERT_NOW(a_open_has_bytes, clk, rst, frame_open, bytes_left != 8'd0)

endmodule

`default_nettype wire

>>> src/iapcf_burst.sv
// ----------------------------------------------------------------------------
// iapcf_burst
// Result register: holds one item's burst of bytes and shifts it out one
// beat per accepted result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "iap_command_framer_core_macros.svh"

module iapcf_burst (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire iapcf_pkg::burst_t burst,
  output logic                   free,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output iapcf_pkg::out_item_t   result
);

  logic [iapcf_pkg::MaxBeats-1:0][7:0] bytes;
  logic [iapcf_pkg::CntW-1:0]          rem;
  logic                                has_end;
  logic                                take;
  logic                                last;

  assign result_valid     = (rem != '0);
  assign take             = result_valid && !result_stall;
  assign last             = (rem == iapcf_pkg::CntW'(1));
  assign free             = (rem == '0) || (last && take);
  assign result.out_byte  = bytes[0];
  assign result.run_last  = last;
  assign result.frame_end = has_end && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load) begin
      rem <= burst.count;
    end else if (take) begin
      rem <= rem - iapcf_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes   <= burst.bytes;
      has_end <= burst.has_end;
    end else if (take) begin
      // advance to the next byte
      bytes <= {8'h00, bytes[iapcf_pkg::MaxBeats-1:1]};
    end
  end

  `IAPCF_ASSERT_NOW(a_load_when_free, clk, rst, load,
                    rem == '0 || (last && take))
  `IAPCF_ASSERT_NEXT(a_rem_step, clk, rst, take && !load,
                     rem == $past(rem) - iapcf_pkg::CntW'(1))

endmodule

`default_nettype wire

>>> src/iap_command_framer_core.sv
// ----------------------------------------------------------------------------
// iap_command_framer_core
// Wraps commands and payload bytes into serial frames:
// AA 55, cmd, len, payload, sum low, sum high, 55 AA.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                 beat
//  item     in   item_valid / item_stall   first, cmd, frame_len, data_byte
//  result   out  result_valid / result_stall out_byte, run_last, frame_end
//
// One result beat per cycle while result_stall is low; an item fills the result
// register with its beats (one for a mid-frame payload byte, five for the byte
// that closes a frame, up to 9 when it opens a frame); a dropped stray byte gives none.
// An accepted item is registered in the skid buffer, then loaded into the free result register.
// item_stall comes from a two-entry skid register and rises only when both
// entries are full. Synchronous reset clears frame state and both buffers.
// ----------------------------------------------------------------------------
`default_nettype none

module iap_command_framer_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_stall,
  input  wire iapcf_pkg::in_item_t item,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output iapcf_pkg::out_item_t     result
);

  logic                head_valid;
  iapcf_pkg::in_item_t head;
  logic                free;
  logic                load;
  iapcf_pkg::burst_t   burst;

  assign load = head_valid && free;

  iapcf_in_buf u_in_buf (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .head_valid (head_valid),
    .head       (head),
    .pop        (load)
  );

  iapcf_frame_calc u_frame_calc (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .item  (head),
    .burst (burst)
  );

  iapcf_burst u_burst (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .burst        (burst),
    .free         (free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire
